FILE: src/espd_pkg.sv
// Shared types and constants for the encoder speed PI duty controller.
package espd_pkg;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SPEED  = 9'b000000010,
        S_ERR    = 9'b000000100,
        S_MUL_P  = 9'b000001000,
        S_MUL_Q  = 9'b000010000,
        S_INCR   = 9'b000100000,
        S_ACC    = 9'b001000000,
        S_MUL_D  = 9'b010000000,
        S_OUT    = 9'b100000000
    } espd_state_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_SPEED_SCALE   = 2'd0,
        REG_GAIN_PRESENT  = 2'd1,
        REG_GAIN_PREVIOUS = 2'd2,
        REG_OUTPUT_SCALE  = 2'd3
    } espd_reg_idx_t;

    localparam int PADDR_W = 4;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int INCR_W  = 49;
    localparam int DUTY_W  = 17;

    localparam logic [31:0] SPEED_SCALE_RST   = 32'd3413;
    localparam logic [31:0] GAIN_PRESENT_RST  = 32'd68813;
    localparam logic [31:0] GAIN_PREVIOUS_RST = 32'hFFFF_0000;
    localparam logic [31:0] OUTPUT_SCALE_RST  = 32'd18989;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;

endpackage

FILE: src/encoder_speed_pi_duty_controller_core.sv
// Encoder speed PI duty controller: sequencer around one shared 33x33 multiplier.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | encoder_count, speed_ref
//  out     | output    | out_valid/out_stall | duty, speed_measured, duty_clamped
//  cfg     | input     | APB psel/penable    | paddr, pwdata, prdata
//
// Each word is accepted from idle and then runs eight sequencer steps, four of
// which share the one multiplier (speed, two PI products, duty scaling).
// in_stall is high from accept until the result is loaded in the output register.
// A stalled result holds the sequencer in its last step; the next word is taken
// while the loaded result still waits in the output register to be taken.
// Reset loads the register defaults and clears state and the accumulator.
module encoder_speed_pi_duty_controller_core
    import espd_pkg::*;
#(
    parameter int ACCUM_WIDTH = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         encoder_count,
    input  logic signed [31:0]  speed_ref,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DUTY_W-1:0]   duty,
    output logic signed [31:0]  speed_measured,
    output logic                duty_clamped,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = ACCUM_WIDTH;
    localparam int SW = ((AW > INCR_W) ? AW : INCR_W) + 1;
    localparam logic signed [SW-1:0] AMAX = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SW-1:0] AMIN = ~AMAX;

    espd_state_t state_reg, state_next;

    logic [31:0] speed_scale_reg, gain_present_reg, gain_previous_reg, output_scale_reg;

    logic [15:0]               count_reg;
    logic signed [31:0]        ref_reg;
    logic [15:0]               last_count_reg;
    logic signed [31:0]        last_error_reg;
    logic signed [AW-1:0]      acc_reg;
    logic signed [31:0]        err_reg;
    logic signed [31:0]        speed_work_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [47:0]        part_reg;
    logic signed [INCR_W-1:0]  incr_reg;

    logic                      out_valid_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic signed [31:0]        speed_out_reg;
    logic                      clamped_reg;

    logic                      in_accept;
    logic                      out_free;
    logic                      cfg_write;
    logic [15:0]               diff;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [31:0]        speed_sat;
    logic signed [32:0]        err_wide;
    logic signed [31:0]        err_sat;
    logic signed [SW-1:0]      acc_ext;
    logic signed [SW-1:0]      acc_sum;
    logic signed [AW-1:0]      acc_new;
    logic [47:0]               dval;
    logic [DUTY_W-1:0]         duty_new;
    logic                      clamped_new;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    assign out_valid      = out_valid_reg;
    assign duty           = duty_reg;
    assign speed_measured = speed_out_reg;
    assign duty_clamped   = clamped_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg   <= SPEED_SCALE_RST;
            gain_present_reg  <= GAIN_PRESENT_RST;
            gain_previous_reg <= GAIN_PREVIOUS_RST;
            output_scale_reg  <= OUTPUT_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (espd_reg_idx_t'(paddr[3:2]))
                REG_SPEED_SCALE:   speed_scale_reg   <= pwdata;
                REG_GAIN_PRESENT:  gain_present_reg  <= pwdata;
                REG_GAIN_PREVIOUS: gain_previous_reg <= pwdata;
                REG_OUTPUT_SCALE:  output_scale_reg  <= pwdata;
                default:           speed_scale_reg   <= speed_scale_reg;
            endcase
        end
    end

    always_comb
    begin
        case (espd_reg_idx_t'(paddr[3:2]))
            REG_SPEED_SCALE:   prdata = speed_scale_reg;
            REG_GAIN_PRESENT:  prdata = gain_present_reg;
            REG_GAIN_PREVIOUS: prdata = gain_previous_reg;
            REG_OUTPUT_SCALE:  prdata = output_scale_reg;
            default:           prdata = '0;
        endcase
    end

    // shared multiplier operand select
    assign diff = count_reg - last_count_reg;

    always_comb
    begin
        case (state_reg)
            S_SPEED:
            begin
                mul_a = {{(MUL_W-16){diff[15]}}, diff};
                mul_b = {1'b0, speed_scale_reg};
            end
            S_MUL_P:
            begin
                mul_a = {gain_present_reg[31], gain_present_reg};
                mul_b = {err_reg[31], err_reg};
            end
            S_MUL_Q:
            begin
                mul_a = {gain_previous_reg[31], gain_previous_reg};
                mul_b = {last_error_reg[31], last_error_reg};
            end
            S_MUL_D:
            begin
                mul_a = {1'b0, acc_reg[31:0]};
                mul_b = {1'b0, output_scale_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // saturate speed and error to 32 bits
    always_comb
    begin
        if ((&prod_reg[PROD_W-1:31]) || !(|prod_reg[PROD_W-1:31]))
            speed_sat = prod_reg[31:0];
        else if (prod_reg[PROD_W-1])
            speed_sat = 32'sh8000_0000;
        else
            speed_sat = 32'sh7FFF_FFFF;
    end

    assign err_wide = {ref_reg[31], ref_reg} - {speed_sat[31], speed_sat};

    always_comb
    begin
        if (err_wide[32] == err_wide[31])
            err_sat = err_wide[31:0];
        else if (err_wide[32])
            err_sat = 32'sh8000_0000;
        else
            err_sat = 32'sh7FFF_FFFF;
    end

    // saturating accumulate
    assign acc_ext = {{(SW-AW){acc_reg[AW-1]}}, acc_reg};
    assign acc_sum = acc_ext + {{(SW-INCR_W){incr_reg[INCR_W-1]}}, incr_reg};

    always_comb
    begin
        if (acc_sum > AMAX)
            acc_new = AMAX[AW-1:0];
        else if (acc_sum < AMIN)
            acc_new = AMIN[AW-1:0];
        else
            acc_new = acc_sum[AW-1:0];
    end

    // duty from scaled accumulator
    assign dval = prod_reg[63:16];

    always_comb
    begin
        if (acc_reg[AW-1] || !(|acc_reg) || !(|output_scale_reg))
        begin
            duty_new    = '0;
            clamped_new = 1'b1;
        end
        else if (|acc_ext[SW-1:32])
        begin
            duty_new    = DUTY_FULL;
            clamped_new = 1'b1;
        end
        else if (|dval[47:16])
        begin
            duty_new    = DUTY_FULL;
            clamped_new = 1'b1;
        end
        else if (!(|dval[15:0]))
        begin
            duty_new    = '0;
            clamped_new = 1'b1;
        end
        else
        begin
            duty_new    = {1'b0, dval[15:0]};
            clamped_new = 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_SPEED;
            S_SPEED: state_next = S_ERR;
            S_ERR:   state_next = S_MUL_P;
            S_MUL_P: state_next = S_MUL_Q;
            S_MUL_Q: state_next = S_INCR;
            S_INCR:  state_next = S_ACC;
            S_ACC:   state_next = S_MUL_D;
            S_MUL_D: state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_count_reg <= '0;
            last_error_reg <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                acc_reg        <= acc_new;
                last_error_reg <= err_reg;
                last_count_reg <= count_reg;
            end
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            count_reg <= encoder_count;
            ref_reg   <= speed_ref;
        end
        if (state_reg == S_SPEED || state_reg == S_MUL_P ||
            state_reg == S_MUL_Q || state_reg == S_MUL_D)
            prod_reg <= mul_p;
        if (state_reg == S_ERR)
        begin
            speed_work_reg <= speed_sat;
            err_reg        <= err_sat;
        end
        // hold the present-error term while the previous-error product runs
        if (state_reg == S_MUL_Q)
            part_reg <= prod_reg[63:16];
        if (state_reg == S_INCR)
            incr_reg <= {part_reg[47], part_reg} + {prod_reg[63], prod_reg[63:16]};
        if (state_reg == S_OUT && out_free)
        begin
            duty_reg      <= duty_new;
            speed_out_reg <= speed_work_reg;
            clamped_reg   <= clamped_new;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_SPEED)
        else $error("accepted word did not start the sequence");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output step");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> duty_reg <= DUTY_FULL)
        else $error("duty above full scale");

    a_unclamped_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !clamped_reg) |-> (duty_reg != '0 && duty_reg != DUTY_FULL))
        else $error("unclamped duty at a limit");
`endif

endmodule

FILE: tb/sv/duty_checker.sv
// Channel monitor, duty predictor and result comparison for the speed PI duty controller.
module duty_checker
    import espd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [15:0]        encoder_count,
    input  logic signed [31:0] speed_ref,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [DUTY_W-1:0]  duty,
    input  logic signed [31:0] speed_measured,
    input  logic               duty_clamped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 in_flight,
    output int                 error_count
);

    localparam int     ACC_W   = 48;
    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint DUTY_ONE_ACC = longint'(1) <<< 32;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic signed [31:0] speed;
        logic               clamped;
    } duty_word_t;

    // Configuration copy
    logic [31:0]        speed_scale_q;
    logic signed [31:0] gain_now_q;
    logic signed [31:0] gain_last_q;
    logic [31:0]        output_scale_q;

    // Controller state copy
    logic [15:0] prev_count;
    longint      prev_error;
    longint      accum;

    duty_word_t  expected_duty_q[$];
    duty_word_t  want;
    int          in_acc;
    int          out_acc;

    function automatic longint sat32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return longint'(32'sh7FFF_FFFF);
        if (v < longint'(32'sh8000_0000))
            return longint'(32'sh8000_0000);
        return v;
    endfunction

    task automatic note_failure(input string what, input longint exp_v, input longint got_v);
        error_count++;
        if (error_count <= 10)
            $display("duty_checker: %s expected %0d got %0d", what, exp_v, got_v);
    endtask

    // Advance the controller state by one word and return the result it causes.
    task automatic predict_pi_step(input logic [15:0] count, input logic signed [31:0] target,
                                   output duty_word_t res);
        logic [15:0] step_u;
        longint      diff;
        longint      speed;
        longint      err;
        longint      incr;
        longint      acc;
        logic [63:0] acc_u;
        logic [63:0] scaled;
        step_u = count - prev_count;
        diff   = longint'($signed(step_u));
        speed  = sat32(diff * longint'(speed_scale_q));
        err    = sat32(longint'(target) - speed);
        // arithmetic shift gives the floor for negative products
        incr   = ((longint'(gain_now_q) * err) >>> 16)
               + ((longint'(gain_last_q) * prev_error) >>> 16);
        acc    = accum + incr;
        if (acc > ACC_MAX)
            acc = ACC_MAX;
        else if (acc < ACC_MIN)
            acc = ACC_MIN;

        if (acc <= 0 || output_scale_q == 32'd0) begin
            res.duty    = '0;
            res.clamped = 1'b1;
        end else if (acc >= DUTY_ONE_ACC) begin
            res.duty    = DUTY_FULL;
            res.clamped = 1'b1;
        end else begin
            acc_u  = acc;
            scaled = (acc_u * {32'd0, output_scale_q}) >> 16;
            if (scaled >= 64'd65536) begin
                res.duty    = DUTY_FULL;
                res.clamped = 1'b1;
            end else if (scaled == 64'd0) begin
                res.duty    = '0;
                res.clamped = 1'b1;
            end else begin
                res.duty    = scaled[DUTY_W-1:0];
                res.clamped = 1'b0;
            end
        end
        res.speed  = speed[31:0];

        prev_count = count;
        prev_error = err;
        accum      = acc;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_q  = SPEED_SCALE_RST;
            gain_now_q     = GAIN_PRESENT_RST;
            gain_last_q    = GAIN_PREVIOUS_RST;
            output_scale_q = OUTPUT_SCALE_RST;
            prev_count     = '0;
            prev_error     = 0;
            accum          = 0;
            expected_duty_q.delete();
            in_flight     <= 0;
        end
        else
        begin
            in_acc  = (in_valid && !in_stall) ? 1 : 0;
            out_acc = (out_valid && !out_stall) ? 1 : 0;

            if (out_acc != 0)
            begin
                if (expected_duty_q.size() == 0)
                    note_failure("unexpected word, duty", 0, longint'(duty));
                else
                begin
                    want = expected_duty_q.pop_front();
                    if (want.duty !== duty)
                        note_failure("duty", longint'(want.duty), longint'(duty));
                    if (want.speed !== speed_measured)
                        note_failure("speed_measured", longint'(want.speed),
                                     longint'(speed_measured));
                    if (want.clamped !== duty_clamped)
                        note_failure("duty_clamped", longint'(want.clamped),
                                     longint'(duty_clamped));
                end
            end

            if (in_acc != 0)
            begin
                predict_pi_step(encoder_count, speed_ref, want);
                expected_duty_q.push_back(want);
            end

            if (psel && penable && pwrite && pready)
            begin
                case (espd_reg_idx_t'(paddr[3:2]))
                    REG_SPEED_SCALE:   speed_scale_q  = pwdata;
                    REG_GAIN_PRESENT:  gain_now_q     = pwdata;
                    REG_GAIN_PREVIOUS: gain_last_q    = pwdata;
                    REG_OUTPUT_SCALE:  output_scale_q = pwdata;
                    default: ;
                endcase
            end

            in_flight <= in_flight + in_acc - out_acc;
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus, reset, watchdog and verdict for the encoder speed PI duty controller.
module tb_top
    import espd_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [15:0]         encoder_count = '0;
    logic signed [31:0]  speed_ref     = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [DUTY_W-1:0]   duty;
    logic signed [31:0]  speed_measured;
    logic                duty_clamped;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    int                  in_flight;
    int                  error_count;
    int                  idle_cycles   = 0;
    int                  burst_left    = 0;
    bit                  hold_off_req  = 1'b0;
    logic [15:0]         last_pos      = '0;

    always #5 clk = ~clk;

    encoder_speed_pi_duty_controller_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .encoder_count  (encoder_count),
        .speed_ref      (speed_ref),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty           (duty),
        .speed_measured (speed_measured),
        .duty_clamped   (duty_clamped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    duty_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .encoder_count  (encoder_count),
        .speed_ref      (speed_ref),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty           (duty),
        .speed_measured (speed_measured),
        .duty_clamped   (duty_clamped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_flight      (in_flight),
        .error_count    (error_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input logic [15:0] count, input logic signed [31:0] target);
        int gap;
        in_valid      <= 1'b1;
        encoder_count <= count;
        speed_ref     <= target;
        last_pos       = count;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 2)
                burst_left = $urandom_range(20, 60);
        end
        // keep valid high across back-to-back words
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly small position steps and references near the working range, some wild ones.
    task automatic send_random_sample();
        int                 pick;
        int                 delta;
        logic signed [31:0] target;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            delta = int'($urandom_range(0, 128)) - 64;
        else if (pick < 90)
            delta = int'($urandom_range(0, 4000)) - 2000;
        else
            delta = int'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 65)
            target = int'($urandom_range(0, 524288)) - 262144;
        else if (pick < 85)
            target = int'($urandom_range(0, 33554432)) - 16777216;
        else if (pick < 96)
            target = $urandom;
        else if (pick < 98)
            target = 32'h7FFF_FFFF;
        else
            target = 32'h8000_0000;
        send_sample(last_pos + 16'(delta), target);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input espd_reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] scale_speed, input logic [31:0] gain_now,
                             input logic [31:0] gain_last, input logic [31:0] scale_out,
                             input int n_words);
        wait_results_drained();
        write_reg(REG_SPEED_SCALE, scale_speed);
        write_reg(REG_GAIN_PRESENT, gain_now);
        write_reg(REG_GAIN_PREVIOUS, gain_last);
        write_reg(REG_OUTPUT_SCALE, scale_out);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        repeat (n_words)
            send_random_sample();
    endtask

    // Receiver: random stall runs, quiet stretches, and a long hold on request.
    initial
    begin
        int r;
        int run;
        bit level;
        wait (rst_n === 1'b1);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                level        = 1'b1;
                run          = 300;
            end
            else if (r < 10)
            begin
                level = 1'b0;
                run   = $urandom_range(40, 120);
            end
            else if (r < 42)
            begin
                level = 1'b1;
                run   = $urandom_range(1, 3);
            end
            else if (r < 45)
            begin
                level = 1'b1;
                run   = $urandom_range(15, 50);
            end
            else
            begin
                level = 1'b0;
                run   = $urandom_range(1, 4);
            end
            out_stall <= level;
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT - 1)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // accumulator of one: duty rounds to zero, then holds
        send_sample(16'h0000, 32'sd1);
        send_sample(16'h0000, 32'sd1);
        send_sample(16'h0000, 32'sd65536);
        // one count back, then the largest steps forward and backward
        send_sample(16'hFFFF, 32'sd0);
        send_sample(16'h7FFE, 32'sd0);
        send_sample(16'hFFFE, 32'sd0);
        // full reference: duty pinned at one
        send_sample(16'hFFFE, 32'h7FFF_FFFF);
        send_sample(16'hFFFE, 32'h7FFF_FFFF);
        // most negative reference against a fast positive speed: error saturates
        send_sample(16'h7FFD, 32'h8000_0000);
        send_sample(16'h7FFD, 32'h8000_0000);
        send_sample(16'h5555, 32'h5555_5555);
        send_sample(16'hAAAA, 32'hAAAA_AAAA);
        send_sample(16'hAAAA, 32'sd0);

        // back-to-back words against a long receiver hold
        hold_off_req = 1'b1;
        burst_left   = 80;
        repeat (230)
            send_random_sample();

        run_phase($urandom, $urandom, $urandom, $urandom, 250);
        run_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 200);
        run_phase(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 150);
        // duty is the accumulator over 2^16: small accumulators round to zero
        run_phase(32'd65536, 32'd65536, 32'hFFFF_0000, 32'd1, 200);
        run_phase($urandom_range(0, 100000), 32'(int'($urandom_range(0, 524288)) - 262144),
                  32'(int'($urandom_range(0, 524288)) - 262144),
                  $urandom_range(0, 1048576), 250);
        run_phase(SPEED_SCALE_RST, GAIN_PRESENT_RST, GAIN_PREVIOUS_RST, OUTPUT_SCALE_RST, 130);

        wait_results_drained();
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
